// ----- hdl/cmpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cmpt_pkg
// Shared types and constants for the prescaled compare timer: transfer
// payloads, action codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package cmpt_pkg;

    // default counter width
    localparam int COUNTER_WIDTH_DEF = 32;

    // action codes carried by an input transfer
    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_SCHEDULE   = 3'd1,
        ACT_READ_COUNT = 3'd2,
        ACT_READ_NEXT  = 3'd3,
        ACT_ACK        = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRESCALER    = 2'd0,
        CFG_AUTO_RELOAD  = 2'd1,
        CFG_GUARD_TIME   = 2'd2,
        CFG_COUNT_ENABLE = 2'd3
    } cfg_index_t;

    // configuration reset values
    localparam logic [15:0] PRESCALER_RST    = 16'd1372;
    localparam logic [31:0] AUTO_RELOAD_RST  = 32'hFFFF_FFFF;
    localparam logic [15:0] GUARD_TIME_RST   = 16'd4;
    localparam logic        COUNT_ENABLE_RST = 1'b1;

    // configuration registers as seen by the timer core
    typedef struct packed {
        logic [15:0] prescaler;
        logic [31:0] auto_reload;
        logic [15:0] guard_time;
        logic        count_enable;
    } cfg_t;

    // input transfer payload
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] target_time;
    } in_item_t;

    // output transfer payload
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        compare_flag;
    } out_item_t;

endpackage

// ----- hdl/compare_timer_with_guarded_schedule.sv -----
// ----------------------------------------------------------------------------
// compare_timer_with_guarded_schedule
// Prescaled up-counter with one compare channel, guarded scheduling and an
// interrupt flag, driven by a stream of tick/schedule/read/ack items.
// ----------------------------------------------------------------------------
// a result is registered in the output register, or in the skid on a stall
// throughput: one item per cycle while the skid stage is empty; the core updates its state in one pass
// a two-entry output buffer (output register plus skid) keeps input open
// while one result waits on a stalled output
// reset: asynchronous, clears timer state, output valids, and loads the
// configuration reset values
module compare_timer_with_guarded_schedule #(
    parameter int COUNTER_WIDTH = cmpt_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  cmpt_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output cmpt_pkg::out_item_t       out_data,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data
);
    import cmpt_pkg::*;

    cfg_t      cfg_reg;
    out_item_t result;
    out_item_t out_data_reg;
    out_item_t skid_data_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      accept;
    logic      out_take;

    // handshake
    assign accept    = in_valid & ~skid_valid_reg;
    assign out_take  = out_valid_reg & ~out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescaler    <= PRESCALER_RST;
            cfg_reg.auto_reload  <= AUTO_RELOAD_RST;
            cfg_reg.guard_time   <= GUARD_TIME_RST;
            cfg_reg.count_enable <= COUNT_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRESCALER:    cfg_reg.prescaler    <= cfg_data[15:0];
                CFG_AUTO_RELOAD:  cfg_reg.auto_reload  <= cfg_data;
                CFG_GUARD_TIME:   cfg_reg.guard_time   <= cfg_data[15:0];
                CFG_COUNT_ENABLE: cfg_reg.count_enable <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // timer core
    cmpt_core #(
        .CNT_W (COUNTER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    // output register and skid stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg  <= skid_valid_reg | accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid stage payloads
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    // skid entry is only occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result with output register empty");

    // a transfer arriving at a stalled full output lands in the skid stage
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    // interrupt is never shown without its compare flag
    a_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.irq || out_data_reg.compare_flag))
        else $error("irq without compare flag");

endmodule

// ----- hdl/cmpt_core.sv -----
// ----------------------------------------------------------------------------
// cmpt_core
// Timer state and per-item logic: prescaler, wrapping counter, compare
// match, guarded schedule and acknowledge. One item per accepted transfer.
// ----------------------------------------------------------------------------
module cmpt_core #(
    parameter int CNT_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  cmpt_pkg::in_item_t item,
    input  cmpt_pkg::cfg_t     cfg,
    output cmpt_pkg::out_item_t result
);
    import cmpt_pkg::*;

    logic [15:0]      prescale_reg, prescale_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] compare_reg, compare_next;
    logic [CNT_W-1:0] sched_reg, sched_next;
    logic             flag_reg, flag_next;
    logic             ien_reg, ien_next;

    logic [CNT_W-1:0] target_w;
    logic [CNT_W-1:0] guard_w;
    logic [CNT_W-1:0] reload_w;
    logic [CNT_W-1:0] step_count;
    logic [CNT_W-1:0] lead_diff;
    logic [CNT_W-1:0] sched_time;
    logic [31:0]      data;

    // operands at counter width
    assign target_w = CNT_W'(item.target_time);
    assign guard_w  = CNT_W'(cfg.guard_time);
    assign reload_w = CNT_W'(cfg.auto_reload);

    // counter step with wrap after the reload value
    assign step_count = (count_reg == reload_w) ? '0 : count_reg + 1'b1;

    // guarded schedule: keep target only if counter is before target - guard
    assign lead_diff  = count_reg - (target_w - guard_w);
    assign sched_time = lead_diff[CNT_W-1] ? target_w : count_reg + guard_w;

    // next state and result for one item
    always_comb
    begin
        prescale_next = prescale_reg;
        count_next    = count_reg;
        compare_next  = compare_reg;
        sched_next    = sched_reg;
        flag_next     = flag_reg;
        ien_next      = ien_reg;
        data          = '0;
        unique case (item.action)
            ACT_TICK:
            begin
                if (cfg.count_enable)
                begin
                    if (prescale_reg < cfg.prescaler)
                    begin
                        prescale_next = prescale_reg + 16'd1;
                    end
                    else
                    begin
                        prescale_next = '0;
                        count_next    = step_count;
                        if (step_count == compare_reg)
                        begin
                            flag_next = 1'b1;
                        end
                    end
                end
            end
            ACT_SCHEDULE:
            begin
                sched_next   = sched_time;
                compare_next = sched_time;
                flag_next    = 1'b0;
                ien_next     = 1'b1;
            end
            ACT_READ_COUNT:
            begin
                data = 32'(count_reg);
            end
            ACT_READ_NEXT:
            begin
                data = 32'(sched_reg);
            end
            ACT_ACK:
            begin
                if (flag_reg)
                begin
                    flag_next  = 1'b0;
                    ien_next   = 1'b0;
                    sched_next = '0;
                end
            end
            default:
            begin
                data = '0;
            end
        endcase
        result.read_data    = data;
        result.irq          = flag_next & ien_next;
        result.compare_flag = flag_next;
    end

    // timer state, updated on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            count_reg    <= '0;
            compare_reg  <= '0;
            sched_reg    <= '0;
            flag_reg     <= 1'b0;
            ien_reg      <= 1'b0;
        end
        else if (accept)
        begin
            prescale_reg <= prescale_next;
            count_reg    <= count_next;
            compare_reg  <= compare_next;
            sched_reg    <= sched_next;
            flag_reg     <= flag_next;
            ien_reg      <= ien_next;
        end
    end

endmodule
